### rtl/core/mrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

  // modbus function codes and fixed frame fields
  localparam logic [7:0] FuncRead   = 8'h03;
  localparam logic [7:0] FuncWrite  = 8'h10;
  localparam logic [7:0] WriteRegsH = 8'h00;
  localparam logic [7:0] WriteRegsL = 8'h02;
  localparam logic [7:0] WriteBytes = 8'h04;

  // crc-16/modbus
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // request kinds
  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  // byte positions in a frame
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] BodyRead       = 4'd6;
  localparam logic [IdxW-1:0] BodyWrite      = 4'd11;
  localparam logic [IdxW-1:0] FrameLastRead  = 4'd7;
  localparam logic [IdxW-1:0] FrameLastWrite = 4'd12;

  localparam logic [7:0] SlaveReset = 8'h01;

  // one request item
  typedef struct packed {
    logic               req_type;
    logic [15:0]        reg_address;
    logic [15:0]        read_count;
    logic signed [31:0] write_value;
  } mrf_req_t;

  // one frame byte item
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } mrf_res_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            emit;
    logic [IdxW-1:0] idx;
  } mrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_write;
  } mrf_status_t;

  // advance the crc register by one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mrf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mrf_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  input  mrf_pkg::mrf_status_t status,
  output mrf_pkg::mrf_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t                      state;
  logic [mrf_pkg::IdxW-1:0]    idx;
  logic [mrf_pkg::IdxW-1:0]    last_idx;
  logic                        emit;
  logic                        emit_last;
  logic                        load;

  // index of the final crc byte for the frame in flight
  assign last_idx  = status.is_write ? mrf_pkg::FrameLastWrite : mrf_pkg::FrameLastRead;

  // one byte per cycle whenever the output register can take it
  assign emit      = (state == ST_BUSY) && status.out_free;
  assign emit_last = emit && (idx == last_idx);

  // a new request may enter while the last byte of the previous one goes out
  assign req_ready = (state == ST_IDLE) || emit_last;
  assign load      = req_valid && req_ready;

  assign cmd.load = load;
  assign cmd.emit = emit;
  assign cmd.idx  = idx;

  // state and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (load) begin
            state <= ST_BUSY;
            idx   <= '0;
          end
        end
        ST_BUSY: begin
          if (emit_last) begin
            idx <= '0;
            if (!load) begin
              state <= ST_IDLE;
            end
          end else if (emit) begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          idx   <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/mrf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mrf_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [7:0]            cfg_wdata,
  input  mrf_pkg::mrf_req_t    req_item,
  input  mrf_pkg::mrf_cmd_t    cmd,
  output mrf_pkg::mrf_status_t status,
  output logic                 frame_valid,
  input  wire                  frame_ready,
  output mrf_pkg::mrf_res_t    frame_item
);

  logic [7:0]               slave_address;
  mrf_pkg::mrf_req_t        req_q;
  logic [15:0]              crc;
  logic [7:0]               cur_byte;
  logic [mrf_pkg::IdxW-1:0] body;
  logic                     in_body;
  logic                     is_last;

  // slave address register
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mrf_pkg::SlaveReset;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  assign body    = (req_q.req_type == mrf_pkg::ReqWrite) ? mrf_pkg::BodyWrite
                                                          : mrf_pkg::BodyRead;
  assign in_body = cmd.idx < body;
  assign is_last = cmd.idx == (body + 4'd1);

  // byte select for the current frame position
  always_comb begin
    cur_byte = 8'h00;
    if (cmd.idx == body) begin
      cur_byte = crc[7:0];
    end else if (is_last) begin
      cur_byte = crc[15:8];
    end else begin
      case (cmd.idx)
        4'd0:    cur_byte = slave_address;
        4'd1:    cur_byte = (req_q.req_type == mrf_pkg::ReqWrite) ? mrf_pkg::FuncWrite
                                                                   : mrf_pkg::FuncRead;
        4'd2:    cur_byte = req_q.reg_address[15:8];
        4'd3:    cur_byte = req_q.reg_address[7:0];
        4'd4:    cur_byte = (req_q.req_type == mrf_pkg::ReqWrite) ? mrf_pkg::WriteRegsH
                                                                   : req_q.read_count[15:8];
        4'd5:    cur_byte = (req_q.req_type == mrf_pkg::ReqWrite) ? mrf_pkg::WriteRegsL
                                                                   : req_q.read_count[7:0];
        4'd6:    cur_byte = mrf_pkg::WriteBytes;
        4'd7:    cur_byte = req_q.write_value[31:24];
        4'd8:    cur_byte = req_q.write_value[23:16];
        4'd9:    cur_byte = req_q.write_value[15:8];
        4'd10:   cur_byte = req_q.write_value[7:0];
        default: cur_byte = 8'h00;
      endcase
    end
  end

  // request capture and running crc
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_item;
      crc   <= mrf_pkg::CrcInit;
    end else if (cmd.emit && in_body) begin
      crc <= mrf_pkg::crc_byte(crc, cur_byte);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (cmd.emit) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame_item.frame_byte <= cur_byte;
      frame_item.last_byte  <= is_last;
    end
  end

  assign status.out_free = !frame_valid || frame_ready;
  assign status.is_write = req_q.req_type == mrf_pkg::ReqWrite;

endmodule

`default_nettype wire

### rtl/core/modbus_rtu_request_framer_core.sv
// modbus rtu request framer
// request channel (req_valid/req_ready/req_item): one item per request, either
// a read of holding registers or a write of two registers with a 32-bit value.
// frame channel (frame_valid/frame_ready/frame_item): the frame bytes in wire
// order, crc-16/modbus low byte then high byte, last_byte set on the final one.
// a read request gives 8 bytes, a write request 13 bytes.
// cfg_we/cfg_wdata write the station address placed in the first byte; write
// it only while no frame is in flight.
// once a request is accepted the sequencer goes busy, and then the first byte
// enters the output register; one byte per cycle while the receiver does not
// stall; the next request is taken in the cycle the last byte enters the output register.
// the rate is set by the byte sequencer, which forms and crc-folds one byte a
// cycle.
// when the receiver stalls, the output register holds its byte and the
// sequencer waits; nothing is lost.
// reset (rst, synchronous) empties the output register, drops any frame in
// progress and sets the station address to 1.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_framer_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  mrf_pkg::mrf_req_t  req_item,
  output logic               frame_valid,
  input  wire                frame_ready,
  output mrf_pkg::mrf_res_t  frame_item,
  input  wire                cfg_we,
  input  wire [7:0]          cfg_wdata
);

  mrf_pkg::mrf_cmd_t    cmd;
  mrf_pkg::mrf_status_t status;

  // byte sequencer
  mrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // request store, byte select, crc and output register
  mrf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_item    (req_item),
    .cmd         (cmd),
    .status      (status),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_item  (frame_item)
  );

endmodule

`default_nettype wire
